// ===== rtl/cmst_pkg.sv =====
// ----------------------------------------------------------------------------
// cmst_pkg: shared types and codes for the compare match system timer
// Command and register select codes, field widths, item and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package cmst_pkg;

    localparam int WORD_W = 32;
    localparam int CMD_W  = 2;
    localparam int SEL_W  = 3;
    localparam int NUM_CMP = 4;
    localparam int CMP_IDX_W = $clog2(NUM_CMP);

    // Command codes; code 3 is unused and does nothing
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    // Register select codes; code 7 is unused
    localparam logic [SEL_W-1:0] SEL_STATUS = 3'd0;
    localparam logic [SEL_W-1:0] SEL_CNT_LO = 3'd1;
    localparam logic [SEL_W-1:0] SEL_CNT_HI = 3'd2;
    localparam logic [SEL_W-1:0] SEL_CMP0   = 3'd3;
    localparam logic [SEL_W-1:0] SEL_CMP1   = 3'd4;
    localparam logic [SEL_W-1:0] SEL_CMP2   = 3'd5;
    localparam logic [SEL_W-1:0] SEL_CMP3   = 3'd6;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [NUM_CMP-1:0] flags_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SEL_W-1:0] reg_sel;
        word_t            write_data;
    } item_t;

    typedef struct packed {
        word_t read_data;
        logic  irq_pending;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/cmst_req_if.sv =====
// ----------------------------------------------------------------------------
// cmst_req_if: request channel
// Valid/ready channel that carries one timer item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmst_req_if
    import cmst_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [SEL_W-1:0] reg_sel;
    word_t            write_data;

    modport source (output valid, output cmd, output reg_sel, output write_data,
                    input ready);
    modport sink   (input valid, input cmd, input reg_sel, input write_data,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/cmst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cmst_rsp_if: response channel
// Valid/ready channel that carries one timer result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmst_rsp_if
    import cmst_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t read_data;
    logic  irq_pending;

    modport source (output valid, output read_data, output irq_pending,
                    input ready);
    modport sink   (input valid, input read_data, input irq_pending,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/cmst_in_stage.sv =====
// ----------------------------------------------------------------------------
// cmst_in_stage: request input register
// Capture one item per transfer; hold it until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cmst_in_stage
    import cmst_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cmst_req_if.sink  req,
    input  wire logic advance,
    output item_t     item,
    output logic      item_valid
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign req.ready  = !valid_reg || advance;
    assign valid_next = req.valid || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= '{cmd: req.cmd, reg_sel: req.reg_sel,
                          write_data: req.write_data};
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/cmst_core.sv =====
// ----------------------------------------------------------------------------
// cmst_core: timer state and single-pass execute
// Holds counter, compare, status and interrupt state; executes one item.
// ----------------------------------------------------------------------------
`default_nettype none

module cmst_core
    import cmst_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire item_t item,
    output result_t    result
);

    word_t  cnt_lo_reg,  cnt_lo_next;
    word_t  cnt_hi_reg,  cnt_hi_next;
    word_t  cmp_reg  [NUM_CMP];
    word_t  cmp_next [NUM_CMP];
    flags_t flags_reg,   flags_next;
    logic   irq_reg,     irq_next;

    logic [2*WORD_W-1:0]  cnt_inc;
    flags_t               match;
    flags_t               hit;
    logic [CMP_IDX_W-1:0] cmp_idx;
    word_t                rd;

    assign cnt_inc = {cnt_hi_reg, cnt_lo_reg} + (2*WORD_W)'(1);
    assign cmp_idx = CMP_IDX_W'(item.reg_sel - SEL_CMP0);
    assign hit     = item.write_data[NUM_CMP-1:0] & flags_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_CMP; k++)
        begin
            match[k] = (cnt_inc[WORD_W-1:0] != '0) &&
                       (cnt_inc[WORD_W-1:0] == cmp_reg[k]);
        end
    end

    always_comb
    begin
        cnt_lo_next = cnt_lo_reg;
        cnt_hi_next = cnt_hi_reg;
        cmp_next    = cmp_reg;
        flags_next  = flags_reg;
        irq_next    = irq_reg;
        rd          = '0;

        case (item.cmd)
            CMD_TICK:
            begin
                // Counter freezes while the interrupt is pending
                if (!irq_reg)
                begin
                    cnt_lo_next = cnt_inc[WORD_W-1:0];
                    cnt_hi_next = cnt_inc[2*WORD_W-1:WORD_W];
                    flags_next  = flags_reg | match;
                    irq_next    = |match;
                end
            end
            CMD_READ:
            begin
                unique case (item.reg_sel) inside
                    SEL_STATUS: rd = WORD_W'(flags_reg);
                    SEL_CNT_LO: rd = cnt_lo_reg;
                    SEL_CNT_HI: rd = cnt_hi_reg;
                    SEL_CMP0, SEL_CMP1, SEL_CMP2, SEL_CMP3: rd = cmp_reg[cmp_idx];
                    default:    rd = '0;
                endcase
            end
            CMD_WRITE:
            begin
                unique case (item.reg_sel) inside
                    SEL_STATUS:
                    begin
                        // Acknowledge while pending, direct load while idle
                        if (irq_reg)
                        begin
                            if (hit != '0)
                            begin
                                flags_next = flags_reg & ~hit;
                                irq_next   = 1'b0;
                            end
                        end
                        else
                        begin
                            flags_next = item.write_data[NUM_CMP-1:0];
                        end
                    end
                    SEL_CNT_LO: cnt_lo_next = item.write_data;
                    SEL_CNT_HI: cnt_hi_next = item.write_data;
                    SEL_CMP0, SEL_CMP1, SEL_CMP2, SEL_CMP3:
                        cmp_next[cmp_idx] = item.write_data;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_lo_reg <= '0;
            cnt_hi_reg <= '0;
            for (int k = 0; k < NUM_CMP; k++)
            begin
                cmp_reg[k] <= '0;
            end
            flags_reg  <= '0;
            irq_reg    <= 1'b0;
        end
        else if (fire)
        begin
            cnt_lo_reg <= cnt_lo_next;
            cnt_hi_reg <= cnt_hi_next;
            cmp_reg    <= cmp_next;
            flags_reg  <= flags_next;
            irq_reg    <= irq_next;
        end
    end

    assign result = '{read_data: rd, irq_pending: irq_next};

endmodule

`default_nettype wire

// ===== rtl/cmst_out_stage.sv =====
// ----------------------------------------------------------------------------
// cmst_out_stage: response output register
// Hold one finished result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cmst_out_stage
    import cmst_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result,
    output logic         slot_free,
    cmst_rsp_if.source   rsp
);

    logic    valid_reg;
    result_t result_reg;

    assign slot_free = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.read_data   = result_reg.read_data;
    assign rsp.irq_pending = result_reg.irq_pending;

endmodule

`default_nettype wire

// ===== rtl/compare_match_system_timer.sv =====
// ----------------------------------------------------------------------------
// compare_match_system_timer: 64-bit system timer with four compare registers
// Path: the request transfer loads the input register; the held item
// executes when the result register has room, and its outcome loads the
// result register, which drives rsp.
// Throughput: one item per cycle, as the core updates its state per item;
// stalls only when the result register is full and not taken.
// Reset: rst_n clears counter, compare values, status and interrupt at once.
// ----------------------------------------------------------------------------
`default_nettype none

module compare_match_system_timer
    import cmst_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cmst_req_if.sink   req,
    cmst_rsp_if.source rsp
);

    // Pipeline: request register -> execute against timer state -> result
    // register. The execute step consumes the held item only when the
    // result register can take the outcome, so state changes exactly once
    // per item and results stay in request order.

    item_t   item;
    logic    item_valid;
    logic    slot_free;
    logic    advance;
    result_t result;

    // Advance the held item when the result register has room
    assign advance = item_valid && slot_free;

    cmst_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    // Tick, read or write; the state register updates on the same edge that
    // loads the result
    cmst_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item),
        .result (result)
    );

    // Hold the result until the sink completes its transfer
    cmst_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .slot_free (slot_free),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/cmst_checker.sv =====
// ----------------------------------------------------------------------------
// cmst_checker: port-level checks for the system timer
// Track items in flight and check stall and ordering behavior at the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cmst_checker
    import cmst_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  req_valid,
    input wire logic  req_ready,
    input wire logic  rsp_valid,
    input wire logic  rsp_ready,
    input wire word_t rsp_read_data,
    input wire logic  rsp_irq_pending
);

    logic       req_xfer;
    logic       rsp_xfer;
    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;

    assign req_xfer = req_valid && req_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (req_xfer && !rsp_xfer)
        begin
            inflight_next = inflight_reg + 2'd1;
        end
        else if (!req_xfer && rsp_xfer)
        begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
        $stable(rsp_irq_pending))
        else $error("result changed while stalled");

    // No result without an item in flight
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> inflight_reg != 2'd0)
        else $error("result without a pending item");

    // At most two items held inside the block
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("more items in flight than stages");

    // Back-pressure only when the result register is full and not taken
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request stalled with result path free");

endmodule

bind compare_match_system_timer cmst_checker u_cmst_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_read_data   (rsp.read_data),
    .rsp_irq_pending (rsp.irq_pending)
);

`default_nettype wire
